FILE: src/button_press_hold_release_debouncer_assert.svh
// Assertion macros used by the debouncer top module.
`ifndef BUTTON_PRESS_HOLD_RELEASE_DEBOUNCER_ASSERT_SVH
`define BUTTON_PRESS_HOLD_RELEASE_DEBOUNCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPHRD_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("debouncer assertion failed");
`define BPHRD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("debouncer assertion failed");
`else
`define BPHRD_ASSERT_IMPL(label, clk, rst, a, c)
`define BPHRD_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: src/bphrd_pkg.sv
`timescale 1ns / 1ps
package bphrd_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLED          = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOUNCE_MS        = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_INTERVAL_MS = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOGGLE_MODE      = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_LEVEL     = 3'd4;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [15:0] BOUNCE_MS_RESET        = 16'd10;
  localparam logic [15:0] HOLD_INTERVAL_MS_RESET = 16'd500;

  typedef struct packed {
    logic kind;
    logic sample_level;
  } in_word_t;

  typedef struct packed {
    logic press_event;
    logic hold_event;
    logic release_event;
    logic toggle_state;
  } out_word_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] bounce_ms;
    logic [15:0] hold_interval_ms;
    logic        toggle_mode;
    logic        active_level;
  } cfg_t;

endpackage

FILE: src/bphrd_cfg_regs.sv
`timescale 1ns / 1ps
module bphrd_cfg_regs
  import bphrd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b1;
      cfg.bounce_ms        <= BOUNCE_MS_RESET;
      cfg.hold_interval_ms <= HOLD_INTERVAL_MS_RESET;
      cfg.toggle_mode      <= 1'b0;
      cfg.active_level     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLED:          cfg.enabled          <= cfg_data[0];
        REG_BOUNCE_MS:        cfg.bounce_ms        <= cfg_data;
        REG_HOLD_INTERVAL_MS: cfg.hold_interval_ms <= cfg_data;
        REG_TOGGLE_MODE:      cfg.toggle_mode      <= cfg_data[0];
        REG_ACTIVE_LEVEL:     cfg.active_level     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/bphrd_core.sv
`timescale 1ns / 1ps
module bphrd_core
  import bphrd_pkg::*;
#(
  parameter int COUNT_WIDTH = 17
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      en,
  input  in_word_t  word,
  output out_word_t result
);

  localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 17;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_INIT =
    (COUNT_WIDTH > 16) ? COUNT_WIDTH'(32'd65536) : CNT_MAX;

  logic                   held, held_next;
  logic                   toggled, toggled_next;
  logic [COUNT_WIDTH-1:0] elapsed, elapsed_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_WIDTH-1:0]   cnt_ext;
  logic                   active;
  logic                   guard_open;
  logic                   hold_due;

  always_comb begin
    cnt_inc    = (elapsed == CNT_MAX) ? elapsed : elapsed + COUNT_WIDTH'(1);
    cnt_ext    = CMP_WIDTH'(cnt_inc);
    active     = (word.sample_level == cfg.active_level);
    guard_open = cfg.enabled && (cnt_ext > CMP_WIDTH'(cfg.bounce_ms));
    hold_due   = cnt_ext > CMP_WIDTH'(cfg.hold_interval_ms);

    held_next            = held;
    toggled_next         = toggled;
    elapsed_next         = elapsed;
    result.press_event   = 1'b0;
    result.hold_event    = 1'b0;
    result.release_event = 1'b0;

    if (word.kind == KIND_CLEAR) begin
      toggled_next         = 1'b0;
      result.release_event = 1'b1;
    end else begin
      elapsed_next = cnt_inc;
      if (guard_open) begin
        if (!held) begin
          if (active) begin
            held_next    = 1'b1;
            elapsed_next = '0;
            if (cfg.toggle_mode) begin
              toggled_next         = !toggled;
              result.press_event   = !toggled;
              result.release_event = toggled;
            end else begin
              result.press_event = 1'b1;
            end
          end
        end else begin
          if (hold_due) begin
            elapsed_next      = '0;
            result.hold_event = !cfg.toggle_mode;
          end
          if (!active) begin
            held_next            = 1'b0;
            elapsed_next         = '0;
            result.release_event = !cfg.toggle_mode;
          end
        end
      end
    end
    result.toggle_state = toggled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      toggled <= 1'b0;
      elapsed <= CNT_INIT;
    end else if (en) begin
      held    <= held_next;
      toggled <= toggled_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

FILE: src/button_press_hold_release_debouncer.sv
// Channel  Signals                        Word        Accepted when
// in       in_valid, in_stall, in_word    in_word_t   in_valid && !in_stall
// out      out_valid, out_stall, out_word out_word_t  out_valid && !out_stall
// cfg      cfg_wr_en, cfg_index, cfg_data  -          cfg_wr_en
//
// Each word is held in the input register, then passes through the event logic
// into the output register.
// A new word is accepted every cycle while the output side keeps taking words.
// Reset is synchronous; it restores the register defaults and the released state.
// A stalled output holds its word; the input stalls only when both registers are full.
`timescale 1ns / 1ps
`include "button_press_hold_release_debouncer_assert.svh"
module button_press_hold_release_debouncer
  import bphrd_pkg::*;
#(
  parameter int COUNT_WIDTH = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_word_t                   in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_word_t                  out_word,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  in_word_t  s1_word;
  logic      advance;
  logic      in_accept;
  out_word_t result;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  bphrd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bphrd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .en     (advance),
    .word   (s1_word),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  `BPHRD_ASSERT_IMPL(a_stall_needs_full, clk, rst, in_stall, s1_valid && out_valid)
  `BPHRD_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)
  `BPHRD_ASSERT_NEXT(a_clear_releases, clk, rst, advance && (s1_word.kind == KIND_CLEAR),
    out_word.release_event && !out_word.toggle_state)
  `BPHRD_ASSERT_IMPL(a_press_hold_apart, clk, rst, out_valid,
    !(out_word.press_event && out_word.hold_event))

endmodule
